// ===== rtl/ppu_pkg.sv =====
`timescale 1ns / 1ps
package ppu_pkg;
    localparam int POOL_SIZE_DEF = 1024;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam logic [31:0] LIFE_MIN = 32'd3277;
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_BURST = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [2:0] REG_EMIT = 3'd0;
    localparam logic [2:0] REG_OMIN = 3'd1;
    localparam logic [2:0] REG_OMAX = 3'd2;
    localparam logic [2:0] REG_BVEL = 3'd3;
    localparam logic [2:0] REG_SPRD = 3'd4;
    localparam logic [2:0] REG_GRAV = 3'd5;
    localparam logic [2:0] REG_LIFE = 3'd6;
    localparam logic [2:0] REG_RATE = 3'd7;

    // signed 66-bit in, saturated signed 32-bit out
    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        begin
            if (v > 66'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
            else if (v < -66'sh0_8000_0000) r = 32'h8000_0000;
            else r = v[31:0];
            return r;
        end
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] a;
        logic [31:0] b;
        begin
            a = s ^ (s << 13);
            b = a ^ (a >> 17);
            return b ^ (b << 5);
        end
    endfunction
endpackage

// ===== rtl/ppu_mul.sv =====
`timescale 1ns / 1ps
// Shared signed 33x33 multiply with arithmetic right shift (floor), registered.
module ppu_mul
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    input  logic [4:0]         shamt,
    output logic signed [65:0] prod_reg
);
    logic signed [65:0] prod_next;
    always_comb
    begin
        prod_next = (66'(a) * 66'(b)) >>> shamt;
    end
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end
endmodule

// ===== rtl/particle_pool_update_top.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Signals
// in      | in  | in_valid, in_stall(out); cmd, time_step, burst_count, read_index
// out     | out | out_valid, out_stall(in); pos_x, pos_y, particle_age, ...
// cfg     | in  | cfg_we, cfg_index, cfg_data
// One transaction at a time. Tick: spawns from dt * rate when positive, then every live
// particle is updated and each removed one is replaced by the last live particle, serialised
// by the single shared multiplier and single-port pools. Active-low async reset clears
// the sequencer, live count, fraction and registers; pool memories are not cleared.
// in_stall is high whenever the sequencer is busy, including while a finished
// result waits behind a stalled out channel.
module particle_pool_update_top #(
    parameter int POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] time_step,
    input  logic [10:0] burst_count,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [31:0] particle_age,
    output logic [31:0] particle_life,
    output logic [10:0] active_count,
    output logic        read_valid,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_RATE2, S_SPAWN, S_SP1, S_SP2, S_SP3, S_SP4, S_SP5, S_SP6,
        S_SPW, S_TRD, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_TW, S_MV, S_MV2,
        S_RD, S_RD2, S_OUT
    } state_t;
    state_t state_reg;

    logic [63:0] cfg_reg [ppu_pkg::NUM_REGS];
    logic [31:0] rnd_reg, frac_reg, dt_reg;
    logic [CW-1:0] live_reg;
    logic [CW-1:0] idx_reg;
    logic [43:0] todo_reg;
    logic [1:0] cmd_reg;
    logic [9:0] ridx_reg;

    logic [63:0] mem_p [POOL_SIZE];
    logic [63:0] mem_v [POOL_SIZE];
    logic [63:0] mem_t [POOL_SIZE];
    logic [63:0] rp_reg, rv_reg, rt_reg;
    logic [AW-1:0] raddr;
    logic [31:0] w0_reg, w1_reg, w2_reg, w3_reg, lf_reg;

    logic signed [32:0] ma, mb;
    logic [4:0] sh;
    logic signed [65:0] prod;
    ppu_mul u_mul (.clk(clk), .a(ma), .b(mb), .shamt(sh), .prod_reg(prod));

    wire signed [31:0] ex = cfg_reg[ppu_pkg::REG_EMIT][63:32];
    wire signed [31:0] ey = cfg_reg[ppu_pkg::REG_EMIT][31:0];
    wire signed [31:0] nx = cfg_reg[ppu_pkg::REG_OMIN][63:32];
    wire signed [31:0] ny = cfg_reg[ppu_pkg::REG_OMIN][31:0];
    wire signed [31:0] xx = cfg_reg[ppu_pkg::REG_OMAX][63:32];
    wire signed [31:0] xy = cfg_reg[ppu_pkg::REG_OMAX][31:0];
    wire signed [31:0] rate = cfg_reg[ppu_pkg::REG_RATE][31:0];
    wire [31:0] rn = ppu_pkg::xorshift(rnd_reg);
    wire signed [32:0] sym = $signed({8'd0, rn[23:0], 1'b0}) - 33'sh100_0000;
    wire signed [32:0] rfr = $signed({9'd0, rn[23:0]});
    wire [32:0] age_sum = {1'b0, rt_reg[63:32]} + {1'b0, dt_reg};
    wire [31:0] age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    wire [AW-1:0] idx_a = idx_reg[AW-1:0];
    wire [CW-1:0] last = live_reg - 1'b1;
    // spawn accumulator: exact dt * rate plus the pending fraction
    wire [63:0] acc_sum = {32'd0, frac_reg} + prod[63:0];

    // multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        sh = 5'd24;
        raddr = idx_a;
        case (state_reg)
            S_RATE: begin sh = 5'd0; ma = {1'b0, dt_reg}; mb = 33'(rate); end
            S_SP1: begin ma = sym; mb = 33'($signed(cfg_reg[ppu_pkg::REG_LIFE][31:0])); end
            S_SP2: begin ma = rfr; mb = 33'(xx) - 33'(nx); end
            S_SP3: begin ma = rfr; mb = 33'(xy) - 33'(ny); end
            S_SP4: begin ma = sym; mb = 33'($signed(cfg_reg[ppu_pkg::REG_SPRD][63:32])); end
            S_SP5: begin ma = sym; mb = 33'($signed(cfg_reg[ppu_pkg::REG_SPRD][31:0])); end
            S_T1: begin sh = 5'd16; ma = 33'($signed(cfg_reg[ppu_pkg::REG_GRAV][63:32]));
                mb = {1'b0, dt_reg}; end
            S_T2: begin sh = 5'd16; ma = 33'($signed(cfg_reg[ppu_pkg::REG_GRAV][31:0]));
                mb = {1'b0, dt_reg}; end
            S_T4: begin sh = 5'd16; ma = 33'($signed(w0_reg)); mb = {1'b0, dt_reg}; end
            S_T5: begin sh = 5'd16; ma = 33'($signed(w1_reg)); mb = {1'b0, dt_reg}; end
            S_MV: raddr = live_reg[AW-1:0];
            S_RD, S_RD2, S_OUT: raddr = ridx_reg[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rp_reg <= mem_p[raddr];
        rv_reg <= mem_v[raddr];
        rt_reg <= mem_t[raddr];
        if (state_reg == S_SPW)
        begin
            mem_p[idx_a] <= {w0_reg, w1_reg};
            mem_v[idx_a] <= {w2_reg, w3_reg};
            mem_t[idx_a] <= {32'd0, lf_reg};
        end
        else if (state_reg == S_TW)
        begin
            mem_p[idx_a] <= {w2_reg, w3_reg};
            mem_v[idx_a] <= {w0_reg, w1_reg};
            mem_t[idx_a] <= {age_sat, rt_reg[31:0]};
        end
        else if (state_reg == S_MV2)
        begin
            mem_p[idx_a] <= rp_reg;
            mem_v[idx_a] <= rv_reg;
            mem_t[idx_a] <= rt_reg;
        end
    end

    logic signed [65:0] lsum;
    always_comb
    begin
        lsum = 66'($signed(cfg_reg[ppu_pkg::REG_LIFE][63:32])) + prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < ppu_pkg::NUM_REGS; i++) cfg_reg[i] <= '0;
            rnd_reg <= '0;
            frac_reg <= '0;
            live_reg <= '0;
            idx_reg <= '0;
            todo_reg <= '0;
            cmd_reg <= '0;
            ridx_reg <= '0;
            dt_reg <= '0;
            w0_reg <= '0; w1_reg <= '0; w2_reg <= '0; w3_reg <= '0; lf_reg <= '0;
            out_valid <= 1'b0;
            pos_x <= '0; pos_y <= '0; particle_age <= '0; particle_life <= '0;
            active_count <= '0; read_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
                if (cfg_index == ppu_pkg::REG_RATE) rnd_reg <= cfg_data[63:32];
            end
            if (out_valid && !out_stall) out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        cmd_reg <= cmd;
                        dt_reg <= time_step;
                        ridx_reg <= read_index;
                        todo_reg <= 44'(burst_count);
                        case (cmd)
                            ppu_pkg::CMD_TICK: state_reg <= S_RATE;
                            ppu_pkg::CMD_BURST: state_reg <= S_SPAWN;
                            ppu_pkg::CMD_READ: state_reg <= S_RD;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                S_RATE:
                    // positive rate: wait for dt * rate from the shared multiplier
                    if (rate > 0) state_reg <= S_RATE2;
                    else
                    begin
                        todo_reg <= '0;
                        state_reg <= S_SPAWN;
                    end
                S_RATE2:
                begin
                    todo_reg <= {12'd0, acc_sum[63:32]};
                    frac_reg <= acc_sum[31:0];
                    state_reg <= S_SPAWN;
                end
                S_SPAWN:
                    if (todo_reg == '0 || live_reg >= CW'(POOL_SIZE))
                    begin
                        if (cmd_reg == ppu_pkg::CMD_TICK)
                        begin
                            idx_reg <= '0;
                            state_reg <= S_TRD;
                        end
                        else state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= live_reg;
                        state_reg <= S_SP1;
                    end
                S_SP1: begin rnd_reg <= rn; state_reg <= S_SP2; end
                S_SP2:
                begin
                    rnd_reg <= rn;
                    if (lsum < $signed(66'(ppu_pkg::LIFE_MIN))) lf_reg <= ppu_pkg::LIFE_MIN;
                    else if (lsum > 66'sh0_7FFF_FFFF) lf_reg <= 32'h7FFF_FFFF;
                    else lf_reg <= lsum[31:0];
                    state_reg <= S_SP3;
                end
                S_SP3:
                begin
                    rnd_reg <= rn;
                    w0_reg <= ppu_pkg::sat32(66'(ex) + 66'(nx) + prod);
                    state_reg <= S_SP4;
                end
                S_SP4:
                begin
                    rnd_reg <= rn;
                    w1_reg <= ppu_pkg::sat32(66'(ey) + 66'(ny) + prod);
                    state_reg <= S_SP5;
                end
                S_SP5:
                begin
                    rnd_reg <= rn;
                    w2_reg <= ppu_pkg::sat32(66'($signed(cfg_reg[ppu_pkg::REG_BVEL][63:32]))
                        + prod);
                    state_reg <= S_SP6;
                end
                S_SP6:
                begin
                    w3_reg <= ppu_pkg::sat32(66'($signed(cfg_reg[ppu_pkg::REG_BVEL][31:0]))
                        + prod);
                    state_reg <= S_SPW;
                end
                S_SPW:
                begin
                    live_reg <= live_reg + 1'b1;
                    todo_reg <= todo_reg - 1'b1;
                    state_reg <= S_SPAWN;
                end
                S_TRD:
                    if (idx_reg >= live_reg) state_reg <= S_OUT;
                    else state_reg <= S_T1;
                S_T1: state_reg <= S_T2;
                S_T2:
                begin
                    w0_reg <= ppu_pkg::sat32(66'($signed(rv_reg[63:32])) + prod);
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    w1_reg <= ppu_pkg::sat32(66'($signed(rv_reg[31:0])) + prod);
                    state_reg <= S_T4;
                end
                S_T4: state_reg <= S_T5;
                S_T5:
                begin
                    w2_reg <= ppu_pkg::sat32(66'($signed(rp_reg[63:32])) + prod);
                    state_reg <= S_T6;
                end
                S_T6:
                begin
                    w3_reg <= ppu_pkg::sat32(66'($signed(rp_reg[31:0])) + prod);
                    state_reg <= S_TW;
                end
                S_TW:
                    // dead: drop it and pull the last live particle into this slot
                    if (age_sat >= rt_reg[31:0])
                    begin
                        live_reg <= last;
                        state_reg <= S_MV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_TRD;
                    end
                S_MV: state_reg <= S_MV2;
                S_MV2: state_reg <= S_TRD;
                S_RD: state_reg <= S_RD2;
                S_RD2: state_reg <= S_OUT;
                S_OUT:
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        active_count <= 11'(live_reg);
                        if (cmd_reg == ppu_pkg::CMD_READ && CW'(ridx_reg) < live_reg)
                        begin
                            pos_x <= rp_reg[63:32];
                            pos_y <= rp_reg[31:0];
                            particle_age <= rt_reg[63:32];
                            particle_life <= rt_reg[31:0];
                            read_valid <= 1'b1;
                        end
                        else
                        begin
                            pos_x <= '0; pos_y <= '0; particle_age <= '0;
                            particle_life <= '0; read_valid <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTH
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(POOL_SIZE)) else $error("live count over pool size");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_OUT) else $error("stray result");
    a_rv_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> active_count != '0) else $error("read_valid");
`endif
endmodule

// ===== dv/particle_pool_update_top_tb.sv =====
`timescale 1ns / 1ps
module particle_pool_update_top_tb;

    localparam int POOL = 1024;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] age;
        logic [31:0] life;
        logic [10:0] count;
        logic        rvalid;
    } particle_rd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = ppu_pkg::CMD_TICK;
    logic [31:0] time_step = '0;
    logic [10:0] burst_count = '0;
    logic [9:0] read_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0] particle_age;
    logic [31:0] particle_life;
    logic [10:0] active_count;
    logic read_valid;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = ppu_pkg::REG_EMIT;
    logic [63:0] cfg_data = '0;

    // shadow of the pool and its control state
    logic [63:0] regs [ppu_pkg::NUM_REGS];
    logic [63:0] pool_pos [POOL];
    logic [63:0] pool_vel [POOL];
    logic [63:0] pool_tim [POOL];
    int unsigned live;
    logic [31:0] frac;
    logic [31:0] rng;

    particle_rd_t expected_reads[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_reads_valid = 0;
    int idle_cycles = 0;
    bit hold_output = 1'b0;
    bit stall_random = 1'b1;

    particle_pool_update_top i_dut (.*);

    always #10 clk = ~clk;

    function automatic longint sx(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // floor division by 2**s of a signed value
    function automatic longint fshift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint draw_frac();
        logic [31:0] s;
        s = rng;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        rng = s;
        return longint'(s[23:0]);
    endfunction

    function automatic longint sym_draw(input longint spread);
        longint r;
        r = draw_frac() * 2 - 64'sd16777216;
        return fshift(r * spread, 24);
    endfunction

    function automatic longint range_draw(input longint lo, input longint hi);
        longint r;
        r = draw_frac();
        return lo + fshift((hi - lo) * r, 24);
    endfunction

    function automatic void spawn_particle();
        longint life;
        logic [31:0] px, py, vx, vy;
        if (live >= POOL) return;
        life = sx(regs[ppu_pkg::REG_LIFE][63:32]) + sym_draw(sx(regs[ppu_pkg::REG_LIFE][31:0]));
        if (life < 3277) life = 3277;
        if (life > 64'sd2147483647) life = 64'sd2147483647;
        px = clip32(sx(regs[ppu_pkg::REG_EMIT][63:32])
                    + range_draw(sx(regs[ppu_pkg::REG_OMIN][63:32]),
                                 sx(regs[ppu_pkg::REG_OMAX][63:32])));
        py = clip32(sx(regs[ppu_pkg::REG_EMIT][31:0])
                    + range_draw(sx(regs[ppu_pkg::REG_OMIN][31:0]),
                                 sx(regs[ppu_pkg::REG_OMAX][31:0])));
        vx = clip32(sx(regs[ppu_pkg::REG_BVEL][63:32])
                    + sym_draw(sx(regs[ppu_pkg::REG_SPRD][63:32])));
        vy = clip32(sx(regs[ppu_pkg::REG_BVEL][31:0])
                    + sym_draw(sx(regs[ppu_pkg::REG_SPRD][31:0])));
        pool_pos[live] = {px, py};
        pool_vel[live] = {vx, vy};
        pool_tim[live] = {32'd0, life[31:0]};
        live++;
    endfunction

    function automatic void spawn_group(input longint unsigned n);
        longint unsigned room;
        room = POOL - live;
        if (n > room) n = room;
        repeat (n) spawn_particle();
    endfunction

    function automatic void advance_pool(input logic [31:0] dt);
        longint rate, gx, gy, dts;
        longint unsigned acc, age;
        logic [31:0] vx, vy, px, py;
        int unsigned i;
        rate = sx(regs[ppu_pkg::REG_RATE][31:0]);
        gx = sx(regs[ppu_pkg::REG_GRAV][63:32]);
        gy = sx(regs[ppu_pkg::REG_GRAV][31:0]);
        dts = longint'({32'd0, dt});
        if (rate > 0) begin
            acc = longint'(frac) + longint'(dt) * rate;
            frac = acc[31:0];
            spawn_group(acc >> 32);
        end
        i = 0;
        while (i < live) begin
            vx = clip32(sx(pool_vel[i][63:32]) + fshift(gx * dts, 16));
            vy = clip32(sx(pool_vel[i][31:0]) + fshift(gy * dts, 16));
            px = clip32(sx(pool_pos[i][63:32]) + fshift(sx(vx) * dts, 16));
            py = clip32(sx(pool_pos[i][31:0]) + fshift(sx(vy) * dts, 16));
            age = longint'(pool_tim[i][63:32]) + longint'(dt);
            if (age > 64'hFFFF_FFFF) age = 64'hFFFF_FFFF;
            if (age >= longint'(pool_tim[i][31:0])) begin
                // swap the last live particle in and revisit this slot
                live--;
                pool_pos[i] = pool_pos[live];
                pool_vel[i] = pool_vel[live];
                pool_tim[i] = pool_tim[live];
            end else begin
                pool_pos[i] = {px, py};
                pool_vel[i] = {vx, vy};
                pool_tim[i] = {age[31:0], pool_tim[i][31:0]};
                i++;
            end
        end
    endfunction

    function automatic particle_rd_t predict_result(input logic [1:0] c, input logic [31:0] dt,
                                                   input logic [10:0] n, input logic [9:0] idx);
        particle_rd_t r;
        r = '0;
        if (c == ppu_pkg::CMD_TICK) advance_pool(dt);
        else if (c == ppu_pkg::CMD_BURST) spawn_group(n);
        else if (c == ppu_pkg::CMD_READ && idx < live) begin
            r.px = pool_pos[idx][63:32];
            r.py = pool_pos[idx][31:0];
            r.age = pool_tim[idx][63:32];
            r.life = pool_tim[idx][31:0];
            r.rvalid = 1'b1;
        end
        r.count = live[10:0];
        return r;
    endfunction

    // Write one register while the block is idle and mirror it.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        regs[idx] = val;
        if (idx == ppu_pkg::REG_RATE) rng = val[63:32];
        @(posedge clk);
    endtask

    // Offer one transaction and hold it until accepted; predict on acceptance.
    task automatic send_cmd(input logic [1:0] c, input logic [31:0] dt,
                            input logic [10:0] n, input logic [9:0] idx);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        time_step <= dt;
        burst_count <= n;
        read_index <= idx;
        @(posedge clk iff (in_valid && !in_stall));
        expected_reads.push_back(predict_result(c, dt, n, idx));
        n_sent++;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drain before a register write, plus slack for work with no result pending.
    task automatic wait_idle();
        while (expected_reads.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [9:0] pick_index();
        if (live != 0 && $urandom_range(0, 4) != 0) return 10'($urandom_range(0, live - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic test_directed_extremes();
        write_reg(ppu_pkg::REG_EMIT, {32'h0001_0000, 32'hFFFF_0000});
        write_reg(ppu_pkg::REG_OMIN, {32'hFFF0_0000, 32'h0000_0000});
        write_reg(ppu_pkg::REG_OMAX, {32'h0010_0000, 32'h0005_0000});
        write_reg(ppu_pkg::REG_BVEL, {32'h0002_0000, 32'h0003_0000});
        write_reg(ppu_pkg::REG_SPRD, {32'h0001_0000, 32'h0000_8000});
        write_reg(ppu_pkg::REG_GRAV, {32'h0000_0000, 32'hFFF6_0000});
        write_reg(ppu_pkg::REG_LIFE, {32'h0002_0000, 32'h0001_0000});
        write_reg(ppu_pkg::REG_RATE, {32'h1234_5678, 32'h0000_0000});
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd0);           // empty pool read
        send_cmd(ppu_pkg::CMD_TICK, 32'd0, 11'd0, 10'd0);           // empty tick
        send_cmd(ppu_pkg::CMD_BURST, 32'd0, 11'd0, 10'd0);          // zero-size burst
        send_cmd(ppu_pkg::CMD_BURST, 32'd0, 11'd5, 10'd0);
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd0);
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd4);
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd5);            // just past live count
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd1023);
        send_cmd(ppu_pkg::CMD_NOP, 32'hFFFF_FFFF, 11'h7FF, 10'h3FF);   // unused code
        send_cmd(ppu_pkg::CMD_TICK, 32'h0000_1000, 11'd0, 10'd0);
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd2);
        send_cmd(ppu_pkg::CMD_TICK, 32'h0000_8000, 11'd0, 10'd0);
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd0);
        send_cmd(ppu_pkg::CMD_TICK, 32'hFFFF_FFFF, 11'd0, 10'd0);   // kill everything
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd0);
        wait_idle();
    endtask

    task automatic test_saturation_and_full_pool();
        // wide spreads and offsets push sums to the rails; tiny life hits the clamp
        write_reg(ppu_pkg::REG_EMIT, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(ppu_pkg::REG_OMIN, {32'h8000_0000, 32'h8000_0000});
        write_reg(ppu_pkg::REG_OMAX, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        write_reg(ppu_pkg::REG_BVEL, {32'h7FFF_0000, 32'h8000_0000});
        write_reg(ppu_pkg::REG_SPRD, {32'h7FFF_FFFF, 32'hFFFF_FFFF});
        write_reg(ppu_pkg::REG_GRAV, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(ppu_pkg::REG_LIFE, {32'h0000_0001, 32'h7FFF_FFFF});
        // negative rate: no spawning
        write_reg(ppu_pkg::REG_RATE, {32'hFFFF_FFFF, 32'h8000_0000});
        send_cmd(ppu_pkg::CMD_BURST, 32'd0, 11'd1024, 10'd0);       // fill pool
        send_cmd(ppu_pkg::CMD_BURST, 32'd0, 11'd3, 10'd0);          // full: ignored
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd1023);
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd0);
        send_cmd(ppu_pkg::CMD_TICK, 32'h0000_0800, 11'd0, 10'd0);
        send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, 10'd0);
        send_cmd(ppu_pkg::CMD_TICK, 32'h7FFF_FFFF, 11'd0, 10'd0);
        wait_idle();
    endtask

    task automatic test_tick_spawning();
        write_reg(ppu_pkg::REG_EMIT, 64'd0);
        write_reg(ppu_pkg::REG_OMIN, {32'hFFFE_0000, 32'hFFFE_0000});
        write_reg(ppu_pkg::REG_OMAX, {32'h0002_0000, 32'h0002_0000});
        write_reg(ppu_pkg::REG_BVEL, {32'h0000_0000, 32'h0004_0000});
        write_reg(ppu_pkg::REG_SPRD, {32'h0000_4000, 32'h0000_4000});
        write_reg(ppu_pkg::REG_GRAV, {32'h0000_0000, 32'hFFF6_0000});
        write_reg(ppu_pkg::REG_LIFE, {32'h0000_8000, 32'h0000_4000});
        write_reg(ppu_pkg::REG_RATE, {$urandom(), 32'h0014_8000});   // 20.5 per second
        repeat (10) send_cmd(ppu_pkg::CMD_TICK, 32'h0000_0444, 11'd0, 10'd0);
        wait_idle();
    endtask

    // Mostly short ticks and small bursts with reads; a few big steps and bursts.
    task automatic test_random_traffic(input int count);
        logic [1:0] c;
        logic [31:0] dt;
        logic [10:0] n;
        int k;
        for (k = 0; k < count; k++) begin
            c = $urandom_range(0, 9) < 4 ? ppu_pkg::CMD_READ
                : ($urandom_range(0, 2) == 0 ? ppu_pkg::CMD_BURST : ppu_pkg::CMD_TICK);
            if ($urandom_range(0, 40) == 0) c = ppu_pkg::CMD_NOP;
            dt = $urandom_range(0, 12) == 0 ? $urandom() : $urandom_range(0, 32'h0000_2000);
            n = $urandom_range(0, 15) == 0 ? 11'($urandom_range(0, 2047))
                : 11'($urandom_range(0, 6));
            send_cmd(c, dt, n, pick_index());
        end
        wait_idle();
    endtask

    task automatic test_random_settings();
        int k;
        for (k = 0; k < 3; k++) begin
            write_reg(ppu_pkg::REG_EMIT, {$urandom(), $urandom()});
            write_reg(ppu_pkg::REG_OMIN,
                      {32'hFFFF_0000 - $urandom_range(0, 32'h40000), $urandom()});
            write_reg(ppu_pkg::REG_OMAX, {$urandom_range(0, 32'h40000), $urandom()});
            write_reg(ppu_pkg::REG_BVEL, {$urandom(), $urandom()});
            write_reg(ppu_pkg::REG_SPRD, {$urandom(), $urandom()});
            write_reg(ppu_pkg::REG_GRAV, {$urandom(), $urandom()});
            write_reg(ppu_pkg::REG_LIFE,
                      {$urandom_range(0, 32'h3_0000), $urandom_range(0, 32'h1_0000)});
            write_reg(ppu_pkg::REG_RATE, {$urandom(), $urandom_range(0, 32'h40_0000)});
            test_random_traffic(33);
        end
    endtask

    // Hold the output for a long stretch while commands keep arriving.
    task automatic test_backpressure();
        stall_random = 1'b0;
        hold_output = 1'b1;
        fork
            begin
                repeat (8) send_cmd(ppu_pkg::CMD_READ, 32'd0, 11'd0, pick_index());
            end
            begin
                repeat (400) @(posedge clk);
                hold_output <= 1'b0;
            end
        join
        stall_random = 1'b1;
        wait_idle();
    endtask

    // Output stall: random gaps, mostly short, occasionally long, some clear runs.
    always @(posedge clk) begin
        if (hold_output) out_stall <= 1'b1;
        else if (!stall_random) out_stall <= 1'b0;
        else if (out_stall) out_stall <= ($urandom_range(0, 9) < 6);
        else out_stall <= ($urandom_range(0, 9) == 0);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk) begin
        particle_rd_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reads.size() == 0) begin
                $error("result with no prediction pending");
                errors++;
            end else begin
                e = expected_reads.pop_front();
                n_checked++;
                if (read_valid) n_reads_valid++;
                if (pos_x !== e.px) begin
                    $error("pos_x exp %h got %h", e.px, pos_x); errors++;
                end
                if (pos_y !== e.py) begin
                    $error("pos_y exp %h got %h", e.py, pos_y); errors++;
                end
                if (particle_age !== e.age) begin
                    $error("particle_age exp %h got %h", e.age, particle_age); errors++;
                end
                if (particle_life !== e.life) begin
                    $error("particle_life exp %h got %h", e.life, particle_life); errors++;
                end
                if (active_count !== e.count) begin
                    $error("active_count exp %0d got %0d", e.count, active_count); errors++;
                end
                if (read_valid !== e.rvalid) begin
                    $error("read_valid exp %b got %b", e.rvalid, read_valid); errors++;
                end
            end
        end
    end

    // Watchdog: sized for a full-pool tick, the longest command; stalls add more.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < ppu_pkg::NUM_REGS; k++) regs[k] = '0;
        live = 0;
        frac = '0;
        rng = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_saturation_and_full_pool();
        test_tick_spawning();
        test_backpressure();
        test_random_settings();
        wait_idle();
        repeat (50) @(posedge clk);
        $display("Sent %0d commands, checked %0d results, %0d valid particle reads,",
                 n_sent, n_checked, n_reads_valid);
        $display("across %0d register settings including saturating and full-pool cases.", 6);
        if (errors == 0 && expected_reads.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ppu_pkg.sv
rtl/ppu_mul.sv
rtl/particle_pool_update_top.sv
dv/particle_pool_update_top_tb.sv
